// ===== rtl/lgs_pkg.sv =====
// Shared types and constants for the life automaton grid step block.
`default_nettype none

package lgs_pkg;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_STEP  = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_IN_USE = 1'd1;

    localparam logic [CFG_DATA_W-1:0] CFG_SIZE_RESET = 7'd64;

    localparam int COORD_W = 6;

    localparam logic [3:0] BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] SURVIVE_COUNT = 4'd2;

endpackage

`default_nettype wire

// ===== rtl/lgs_cmd_if.sv =====
// Command channel carrying one grid command word per handshake.
`default_nettype none

interface lgs_cmd_if
    import lgs_pkg::*;
();
    logic               valid;
    logic               ready;
    t_cmd               command;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               value;

    modport source (output valid, output command, output row, output col, output value,
                    input ready);
    modport sink   (input valid, input command, input row, input col, input value,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/lgs_res_if.sv =====
// Result channel carrying one result word per handshake.
`default_nettype none

interface lgs_res_if;
    logic valid;
    logic ready;
    logic cell_alive;
    logic any_alive;
    logic out_of_range;

    modport source (output valid, output cell_alive, output any_alive, output out_of_range,
                    input ready);
    modport sink   (input valid, input cell_alive, input any_alive, input out_of_range,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/life_automaton_grid_step.sv =====
// Top level of the life automaton grid: command sequencer, grid memory and row unit.
//
//  Channel  | Direction | Word contents
//  ---------+-----------+-------------------------------------------
//  i_cmd    | in        | command, row, col, value
//  o_res    | out       | cell_alive, any_alive, out_of_range
//  i_cfg_*  | in        | rows_in_use (index 0), cols_in_use (index 1)
//
// An in-range write or read passes through accept, a memory access state, and the result load.
// An out-of-range access or an unused command skips the memory access state.
// During a step the row unit handles one row per cycle
// while the grid memory delivers the row below and takes back the row above.
// After reset a clearing pass writes every row dead, with i_cmd held not ready until it ends.
// A finished result waits in an output register, and the sequencer holds it until o_res is free.
`default_nettype none

module life_automaton_grid_step
    import lgs_pkg::*;
#(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    lgs_cmd_if.sink                    i_cmd,
    lgs_res_if.source                  o_res
);
    localparam int RA_W  = $clog2(MAX_ROWS);
    localparam int CI_W  = $clog2(MAX_COLS);
    localparam int CNT_W = $clog2(MAX_ROWS + 2);
    localparam int EW    = (CNT_W > CFG_DATA_W) ? CNT_W : CFG_DATA_W;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACCESS,
        ST_STEP,
        ST_RESULT
    } t_state;

    t_state                r_state, n_state;
    logic [EW-1:0]         r_idx, n_idx;
    t_cmd                  r_cmd, n_cmd;
    logic [COORD_W-1:0]    r_row, n_row;
    logic [COORD_W-1:0]    r_col, n_col;
    logic                  r_val, n_val;
    logic [MAX_COLS-1:0]   r_prev, n_prev;
    logic [MAX_COLS-1:0]   r_cur, n_cur;
    logic                  r_any, n_any;
    logic                  r_res_alive, n_res_alive;
    logic                  r_res_oor, n_res_oor;
    logic                  r_out_valid, n_out_valid;
    logic                  r_out_alive, n_out_alive;
    logic                  r_out_any, n_out_any;
    logic                  r_out_oor, n_out_oor;
    logic [CFG_DATA_W-1:0] r_rows_cfg;
    logic [CFG_DATA_W-1:0] r_cols_cfg;

    logic [EW-1:0]         eff_rows;
    logic [CFG_DATA_W-1:0] eff_cols;
    logic [MAX_COLS-1:0]   col_mask;
    logic                  accept;
    logic                  in_range;
    logic [EW-1:0]         in_row_ext;
    logic [EW-1:0]         row_ext;
    logic [EW-1:0]         idx_p1;
    logic [EW-1:0]         idx_m1;
    logic [MAX_COLS-1:0]   below;
    logic [MAX_COLS-1:0]   unit_next;
    logic                  unit_any;

    logic                  ram_we;
    logic [RA_W-1:0]       ram_waddr;
    logic [MAX_COLS-1:0]   ram_wdata;
    logic                  ram_re;
    logic [RA_W-1:0]       ram_raddr;
    logic [MAX_COLS-1:0]   ram_rdata;

    always_comb begin
        if (r_rows_cfg == '0) begin
            eff_rows = EW'(1);
        end else if (EW'(r_rows_cfg) > EW'(MAX_ROWS)) begin
            eff_rows = EW'(MAX_ROWS);
        end else begin
            eff_rows = EW'(r_rows_cfg);
        end
        if (r_cols_cfg == '0) begin
            eff_cols = CFG_DATA_W'(1);
        end else if (r_cols_cfg > CFG_DATA_W'(MAX_COLS)) begin
            eff_cols = CFG_DATA_W'(MAX_COLS);
        end else begin
            eff_cols = r_cols_cfg;
        end
        for (int c = 0; c < MAX_COLS; c++) begin
            col_mask[c] = CFG_DATA_W'(c) < eff_cols;
        end
    end

    assign i_cmd.ready = (r_state == ST_IDLE);
    assign accept      = i_cmd.valid && (r_state == ST_IDLE);
    assign in_row_ext  = EW'(i_cmd.row);
    assign in_range    = (in_row_ext < eff_rows) && (CFG_DATA_W'(i_cmd.col) < eff_cols);
    assign row_ext     = EW'(r_row);
    assign idx_p1      = r_idx + EW'(1);
    assign idx_m1      = r_idx - EW'(1);
    assign below       = (r_idx < eff_rows) ? ram_rdata : '0;

    lgs_row_unit #(
        .COLS (MAX_COLS)
    ) u_row_unit (
        .i_above (r_prev),
        .i_cur   (r_cur),
        .i_below (below),
        .i_mask  (col_mask),
        .o_next  (unit_next),
        .o_any   (unit_any)
    );

    lgs_ram #(
        .WIDTH (MAX_COLS),
        .DEPTH (MAX_ROWS)
    ) u_grid_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_cmd       = r_cmd;
        n_row       = r_row;
        n_col       = r_col;
        n_val       = r_val;
        n_prev      = r_prev;
        n_cur       = r_cur;
        n_any       = r_any;
        n_res_alive = r_res_alive;
        n_res_oor   = r_res_oor;
        n_out_valid = r_out_valid && !o_res.ready;
        n_out_alive = r_out_alive;
        n_out_any   = r_out_any;
        n_out_oor   = r_out_oor;
        ram_we      = 1'b0;
        ram_waddr   = row_ext[RA_W-1:0];
        ram_wdata   = ram_rdata;
        ram_re      = 1'b0;
        ram_raddr   = idx_p1[RA_W-1:0];

        unique case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx[RA_W-1:0];
                ram_wdata = '0;
                if (r_idx == EW'(MAX_ROWS - 1)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_idx = idx_p1;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    ram_re      = 1'b1;
                    ram_raddr   = (i_cmd.command == CMD_STEP) ? '0 : in_row_ext[RA_W-1:0];
                    n_cmd       = i_cmd.command;
                    n_row       = i_cmd.row;
                    n_col       = i_cmd.col;
                    n_val       = i_cmd.value;
                    n_idx       = '0;
                    n_prev      = '0;
                    n_any       = 1'b0;
                    n_res_alive = 1'b0;
                    n_res_oor   = 1'b0;
                    unique case (i_cmd.command) inside
                        CMD_STEP: begin
                            n_state = ST_STEP;
                        end
                        CMD_WRITE, CMD_READ: begin
                            n_res_oor = !in_range;
                            n_state   = in_range ? ST_ACCESS : ST_RESULT;
                        end
                        CMD_NONE: begin
                            n_state = ST_RESULT;
                        end
                        default: begin
                            n_state = ST_RESULT;
                        end
                    endcase
                end
            end
            ST_ACCESS: begin
                if (r_cmd == CMD_WRITE) begin
                    ram_we                   = 1'b1;
                    ram_wdata[r_col[CI_W-1:0]] = r_val;
                end else begin
                    n_res_alive = ram_rdata[r_col[CI_W-1:0]];
                end
                n_state = ST_RESULT;
            end
            ST_STEP: begin
                ram_re = (idx_p1 < eff_rows);
                n_cur  = below;
                if (r_idx != '0) begin
                    ram_we    = 1'b1;
                    ram_waddr = idx_m1[RA_W-1:0];
                    ram_wdata = unit_next;
                    n_any     = r_any | unit_any;
                    n_prev    = r_cur;
                end
                if (r_idx == eff_rows) begin
                    n_state = ST_RESULT;
                end else begin
                    n_idx = idx_p1;
                end
            end
            ST_RESULT: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid = 1'b1;
                    n_out_alive = r_res_alive;
                    n_out_any   = (r_cmd == CMD_STEP) && r_any;
                    n_out_oor   = r_res_oor;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
            r_rows_cfg  <= CFG_SIZE_RESET;
            r_cols_cfg  <= CFG_SIZE_RESET;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_ROWS_IN_USE: r_rows_cfg <= i_cfg_data;
                    CFG_COLS_IN_USE: r_cols_cfg <= i_cfg_data;
                    default: ;
                endcase
            end
        end
        r_cmd       <= n_cmd;
        r_row       <= n_row;
        r_col       <= n_col;
        r_val       <= n_val;
        r_prev      <= n_prev;
        r_cur       <= n_cur;
        r_any       <= n_any;
        r_res_alive <= n_res_alive;
        r_res_oor   <= n_res_oor;
        r_out_alive <= n_out_alive;
        r_out_any   <= n_out_any;
        r_out_oor   <= n_out_oor;
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.cell_alive   = r_out_alive;
    assign o_res.any_alive    = r_out_any;
    assign o_res.out_of_range = r_out_oor;
endmodule

`default_nettype wire

// ===== rtl/lgs_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module lgs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

`default_nettype wire

// ===== rtl/lgs_row_unit.sv =====
// Shared row unit that computes the next generation of one grid row.
`default_nettype none

module lgs_row_unit
    import lgs_pkg::*;
#(
    parameter int COLS = 64
) (
    input  wire logic [COLS-1:0] i_above,
    input  wire logic [COLS-1:0] i_cur,
    input  wire logic [COLS-1:0] i_below,
    input  wire logic [COLS-1:0] i_mask,
    output      logic [COLS-1:0] o_next,
    output      logic            o_any
);
    logic [COLS-1:0] a;
    logic [COLS-1:0] m;
    logic [COLS-1:0] b;
    logic [COLS-1:0] life;

    assign a = i_above & i_mask;
    assign m = i_cur & i_mask;
    assign b = i_below & i_mask;

    always_comb begin
        logic [COLS-1:0] al, ar, ml, mr, bl, br;
        logic [3:0]      n;
        al = a << 1;
        ar = a >> 1;
        ml = m << 1;
        mr = m >> 1;
        bl = b << 1;
        br = b >> 1;
        for (int c = 0; c < COLS; c++) begin
            n = 4'(a[c]) + 4'(b[c]) + 4'(al[c]) + 4'(ar[c])
              + 4'(ml[c]) + 4'(mr[c]) + 4'(bl[c]) + 4'(br[c]);
            life[c] = (n == BIRTH_COUNT) || (m[c] && (n == SURVIVE_COUNT));
        end
        life = life & i_mask;
    end

    assign o_next = (i_cur & ~i_mask) | life;
    assign o_any  = |life;
endmodule

`default_nettype wire
